// ===== rtl/nrle_pkg.sv =====
// nrle_pkg: shared types and constants for the nibble run-length scan-line decoder
// holds the beat structs, the opcode codes and the decode phase encoding
// no dependencies
`default_nettype none

package nrle_pkg;

  localparam int unsigned MAX_LINE_DEF = 8192;
  localparam int unsigned LEN_W        = 14;   // line lengths and capacity
  localparam int unsigned RUN_W        = 9;    // 1..256 pixels in one run
  localparam int unsigned LEFT_W       = 11;   // text length reaches 2047 bytes
  localparam int unsigned RES_MAX      = 3;    // most results one byte can cause
  localparam int unsigned CNT_W        = 2;
  localparam int unsigned CAP_RESET    = 4096;
  localparam int unsigned CAP_HW_LIM   = 16383;

  // opcodes (low nibble of an opcode byte)
  localparam logic [3:0] OP_EOL     = 4'd0;
  localparam logic [3:0] OP_TEXT    = 4'd1;
  localparam logic [3:0] OP_INSTR   = 4'd2;
  localparam logic [3:0] OP_RUN_LO  = 4'd4;
  localparam logic [3:0] OP_RUN_HI  = 4'd9;
  localparam logic [3:0] OP_RUN_LEN = 4'd10;
  localparam logic [3:0] OP_RAW1    = 4'd11;
  localparam logic [3:0] OP_RAW_PR  = 4'd12;
  localparam logic [3:0] OP_RAW_HD  = 4'd13;

  localparam logic [LEFT_W-1:0] INSTR_BYTES = LEFT_W'(8);
  localparam logic [RUN_W-1:0]  RUN_OFFSET  = RUN_W'(2);

  typedef enum logic [5:0] {
    PH_OP        = 6'b000001,
    PH_TEXT_LEN  = 6'b000010,
    PH_SKIP      = 6'b000100,
    PH_RUN_LEN   = 6'b001000,
    PH_RAW_HEAD  = 6'b010000,
    PH_RAW_PAIRS = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic [7:0]       pixel;
    logic [RUN_W-1:0] run_count;
    logic             overflow;
    logic             line_end;
    logic [LEN_W-1:0] line_length;
    logic             last_of_item;
  } out_t;

  // results of one decoded byte, handed from the core to the result buffer
  typedef struct packed {
    out_t [RES_MAX-1:0] res;
    logic [CNT_W-1:0]   cnt;
  } step_t;

endpackage

`default_nettype wire

// ===== rtl/nrle_core.sv =====
// nrle_core: decode state and the single-pass decode of one stream byte
// produces up to three results per byte, updates state when the byte is taken
// depends on nrle_pkg
`default_nettype none

module nrle_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         fire_i,
  input  wire nrle_pkg::in_t                in_i,
  input  wire logic [nrle_pkg::LEN_W-1:0]   cap_i,
  output nrle_pkg::step_t                   step_o
);
  import nrle_pkg::*;

  typedef struct packed {
    out_t             r;
    logic [LEN_W-1:0] lc;
  } place_t;

  phase_e            phase_q, phase_d;
  logic [3:0]        held_q, held_d;
  logic [LEFT_W-1:0] left_q, left_d;
  logic [LEN_W-1:0]  lc_q, lc_d;

  function automatic out_t mk_res(logic [3:0] code, logic [RUN_W-1:0] run, logic ovf,
                                  logic eol, logic [LEN_W-1:0] len);
    out_t r;
    r.pixel        = {code, code};  // 17 * code
    r.run_count    = run;
    r.overflow     = ovf;
    r.line_end     = eol;
    r.line_length  = len;
    r.last_of_item = 1'b0;
    return r;
  endfunction

  // a single pixel is a run of one: it fits exactly when the count is below capacity
  function automatic place_t place(logic [LEN_W-1:0] lc, logic [LEN_W-1:0] cap,
                                   logic [3:0] code, logic [RUN_W-1:0] run);
    place_t           p;
    logic [LEN_W:0]   sum;
    sum = {1'b0, lc} + (LEN_W+1)'(run);
    if (sum > {1'b0, cap}) begin
      p.r  = mk_res(4'd0, '0, 1'b1, 1'b0, lc);
      p.lc = lc;
    end else begin
      p.r  = mk_res(code, run, 1'b0, 1'b0, sum[LEN_W-1:0]);
      p.lc = sum[LEN_W-1:0];
    end
    return p;
  endfunction

  always_comb begin
    logic [7:0]         b;
    logic [3:0]         op;
    logic [3:0]         val;
    logic [CNT_W-1:0]   n;
    logic [LEN_W-1:0]   lc;
    out_t [RES_MAX-1:0] rr;
    place_t             pr;

    b       = in_i.stream_byte;
    op      = b[3:0];
    val     = b[7:4];
    n       = '0;
    lc      = lc_q;
    rr      = '0;
    pr      = '0;
    phase_d = phase_q;
    held_d  = held_q;
    left_d  = left_q;

    unique case (phase_q)
      PH_TEXT_LEN: begin
        left_d  = {held_q[2:0], b};
        held_d  = '0;
        phase_d = (left_d != '0) ? PH_SKIP : PH_OP;
      end
      PH_SKIP: begin
        if (left_q != '0) left_d = left_q - LEFT_W'(1);
        if (left_d == '0) phase_d = PH_OP;
      end
      PH_RUN_LEN: begin
        pr      = place(lc, cap_i, held_q, RUN_W'(b) + RUN_W'(1));
        rr[n]   = pr.r;
        lc      = pr.lc;
        n       = n + CNT_W'(1);
        held_d  = '0;
        phase_d = PH_OP;
      end
      PH_RAW_HEAD: begin
        pr      = place(lc, cap_i, b[7:4], RUN_W'(1));
        rr[n]   = pr.r;
        lc      = pr.lc;
        n       = n + CNT_W'(1);
        left_d  = LEFT_W'({held_q, b[3:0]}) + LEFT_W'(1);
        held_d  = '0;
        phase_d = PH_RAW_PAIRS;
      end
      PH_RAW_PAIRS: begin
        pr    = place(lc, cap_i, b[3:0], RUN_W'(1));
        rr[n] = pr.r;
        lc    = pr.lc;
        n     = n + CNT_W'(1);
        pr    = place(lc, cap_i, b[7:4], RUN_W'(1));
        rr[n] = pr.r;
        lc    = pr.lc;
        n     = n + CNT_W'(1);
        if (left_q != '0) left_d = left_q - LEFT_W'(1);
        if (left_d == '0) phase_d = PH_OP;
      end
      PH_OP: begin
        // full line: close it before decoding anything but an end of line
        if (op != OP_EOL && lc >= cap_i) begin
          rr[n] = mk_res(4'd0, '0, 1'b0, 1'b1, lc);
          lc    = '0;
          n     = n + CNT_W'(1);
        end
        unique case (op) inside
          OP_EOL: begin
            rr[n] = mk_res(4'd0, '0, 1'b0, 1'b1, lc);
            lc    = '0;
            n     = n + CNT_W'(1);
          end
          OP_TEXT: begin
            held_d  = {1'b0, b[7:5]};
            phase_d = PH_TEXT_LEN;
          end
          OP_INSTR: begin
            left_d  = INSTR_BYTES;
            phase_d = PH_SKIP;
          end
          [OP_RUN_LO:OP_RUN_HI]: begin
            pr    = place(lc, cap_i, val, RUN_W'(op) - RUN_OFFSET);
            rr[n] = pr.r;
            lc    = pr.lc;
            n     = n + CNT_W'(1);
          end
          OP_RUN_LEN: begin
            held_d  = val;
            phase_d = PH_RUN_LEN;
          end
          OP_RAW1: begin
            pr    = place(lc, cap_i, val, RUN_W'(1));
            rr[n] = pr.r;
            lc    = pr.lc;
            n     = n + CNT_W'(1);
          end
          OP_RAW_PR: begin
            left_d  = LEFT_W'(val) + LEFT_W'(1);
            phase_d = PH_RAW_PAIRS;
          end
          OP_RAW_HD: begin
            held_d  = val;
            phase_d = PH_RAW_HEAD;
          end
          default: ;  // unused opcodes are ignored
        endcase
      end
      default: phase_d = PH_OP;
    endcase

    // stream end: close the line unless this byte already did, drop any open record
    if (in_i.stream_end) begin
      if (n == '0 || !rr[n - CNT_W'(1)].line_end) begin
        rr[n] = mk_res(4'd0, '0, 1'b0, 1'b1, lc);
        lc    = '0;
        n     = n + CNT_W'(1);
      end
      phase_d = PH_OP;
      held_d  = '0;
      left_d  = '0;
    end

    if (n != '0) rr[n - CNT_W'(1)].last_of_item = 1'b1;

    lc_d       = lc;
    step_o.res = rr;
    step_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OP;
      held_q  <= '0;
      left_q  <= '0;
      lc_q    <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      left_q  <= left_d;
      lc_q    <= lc_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nibble_rle_scanline_decoder.sv =====
// nibble_rle_scanline_decoder: top level of the nibble run-length scan-line decoder
// input register, capacity register and a three-entry result buffer around nrle_core
// depends on nrle_pkg and nrle_core
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+--------------------------------
//   input    | in_valid_i / in_ready_o    | in_data_i  (stream byte, end)
//   result   | out_valid_o / out_ready_i  | out_data_o (one result beat)
//   config   | cfg_we_i                   | cfg_wdata_i (line capacity)
//
// a byte is registered on acceptance and decoded from that register into the result
// buffer once the buffer is free; its results then leave one beat per cycle while
// out_ready_i is high, and the buffer drain sets the rate.
// a byte with no results is retired without waiting for the buffer.
// reset clears the decode state, empties both stages and sets capacity to 4096, or to MAX_LINE if smaller.
`default_nettype none

module nibble_rle_scanline_decoder #(
  parameter int unsigned MAX_LINE = nrle_pkg::MAX_LINE_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire nrle_pkg::in_t              in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output nrle_pkg::out_t                  out_data_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [nrle_pkg::LEN_W-1:0] cfg_wdata_i
);
  import nrle_pkg::*;

  localparam int unsigned CapLim = (MAX_LINE > CAP_HW_LIM) ? CAP_HW_LIM : MAX_LINE;
  localparam int unsigned CapRst = (CAP_RESET > CapLim) ? CapLim : CAP_RESET;

  logic [LEN_W-1:0]   cap_q;
  in_t                in_q;
  logic               in_vld_q;
  out_t [RES_MAX-1:0] buf_q;
  logic [CNT_W-1:0]   cnt_q, rd_q;
  step_t              step;
  logic               out_acc, buf_free, fire;

  // capacity is held already clamped to 1..limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= LEN_W'(CapRst);
    end else if (cfg_we_i) begin
      if (cfg_wdata_i == '0) cap_q <= LEN_W'(1);
      else if (cfg_wdata_i > LEN_W'(CapLim)) cap_q <= LEN_W'(CapLim);
      else cap_q <= cfg_wdata_i;
    end
  end

  assign out_acc  = out_valid_o && out_ready_i;
  assign buf_free = (cnt_q == '0) || (out_acc && rd_q == cnt_q - CNT_W'(1));
  assign fire     = in_vld_q && (buf_free || step.cnt == '0);
  assign in_ready_o = !in_vld_q || fire;

  nrle_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .in_i   (in_q),
    .cap_i  (cap_q),
    .step_o (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (fire && step.cnt != '0) begin
      cnt_q <= step.cnt;
      rd_q  <= '0;
    end else if (out_acc) begin
      if (rd_q == cnt_q - CNT_W'(1)) begin
        cnt_q <= '0;
        rd_q  <= '0;
      end else begin
        rd_q <= rd_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && step.cnt != '0) buf_q <= step.res;
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = buf_q[rd_q];

endmodule

`default_nettype wire

// ===== sim/tb_nibble_rle_scanline_decoder.sv =====
// tb_nibble_rle_scanline_decoder: self-checking bench for the nibble run-length scan-line decoder
// drives encoded stream beats, predicts every result beat in a behavioural decoder and compares
// depends on nrle_pkg and nibble_rle_scanline_decoder
`default_nettype none

module tb_nibble_rle_scanline_decoder;
  import nrle_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned PRESSURE_PH  = 3;
  localparam logic [3:0]  OP_SPARE_A   = 4'd3;
  localparam logic [3:0]  OP_SPARE_B   = 4'd14;
  localparam logic [3:0]  OP_SPARE_C   = 4'd15;
  localparam logic [LEN_W-1:0] PHASE_CAP [NUM_PHASES] =
    '{14'd20, 14'd1, 14'd0, 14'd8192, 14'd16383, 14'd300, 14'd37, 14'd4096};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             stream_valid = 1'b0;
  logic             stream_ready;
  in_t              stream_beat = '0;
  logic             res_valid;
  logic             res_ready = 1'b0;
  out_t             res_beat;
  logic             cap_we = 1'b0;
  logic [LEN_W-1:0] cap_wdata = '0;

  in_t  stream_q [$];
  out_t decoded_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned end_pct = 0;
  int unsigned counted_items = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  // decoder state mirrored by the predictor
  phase_e           dec_phase = PH_OP;
  logic [3:0]       held_nib = '0;
  int unsigned      skip_left = 0;
  int unsigned      line_cnt = 0;
  logic [LEN_W-1:0] cap_reg = LEN_W'(CAP_RESET);
  out_t             res_buf [RES_MAX];
  int unsigned      res_n;
  out_t             exp_res;

  nibble_rle_scanline_decoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stream_valid),
    .in_ready_o  (stream_ready),
    .in_data_i   (stream_beat),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_data_o  (res_beat),
    .cfg_we_i    (cap_we),
    .cfg_wdata_i (cap_wdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned cap_eff();
    int unsigned lim;
    int unsigned c;
    lim = (MAX_LINE_DEF > CAP_HW_LIM) ? CAP_HW_LIM : MAX_LINE_DEF;
    c = int'(cap_reg);
    if (c < 1) c = 1;
    if (c > lim) c = lim;
    return c;
  endfunction

  task automatic add_result(input logic [7:0] pix, input int unsigned run, input bit ovf,
                            input bit eol, input int unsigned len);
    out_t r;
    r.pixel        = pix;
    r.run_count    = RUN_W'(run);
    r.overflow     = ovf;
    r.line_end     = eol;
    r.line_length  = LEN_W'(len);
    r.last_of_item = 1'b0;
    if (res_n < RES_MAX) begin
      res_buf[res_n] = r;
      res_n++;
    end
  endtask

  task automatic close_line();
    add_result(8'd0, 0, 1'b0, 1'b1, line_cnt);
    line_cnt = 0;
  endtask

  // a run either fits whole or is dropped whole
  task automatic place_run(input logic [3:0] code, input int unsigned run);
    if (line_cnt + run > cap_eff()) begin
      add_result(8'd0, 0, 1'b1, 1'b0, line_cnt);
    end else begin
      line_cnt += run;
      add_result({code, code}, run, 1'b0, 1'b0, line_cnt);
    end
  endtask

  task automatic place_pixel(input logic [3:0] code);
    if (line_cnt < cap_eff()) begin
      line_cnt += 1;
      add_result({code, code}, 1, 1'b0, 1'b0, line_cnt);
    end else begin
      add_result(8'd0, 0, 1'b1, 1'b0, line_cnt);
    end
  endtask

  task automatic decode_byte(input in_t beat);
    logic [7:0] b;
    logic [3:0] op;
    logic [3:0] hi;
    b  = beat.stream_byte;
    op = b[3:0];
    hi = b[7:4];
    res_n = 0;
    case (dec_phase)
      PH_TEXT_LEN: begin
        skip_left = int'(held_nib[2:0]) * 256 + int'(b);
        held_nib = '0;
        dec_phase = (skip_left != 0) ? PH_SKIP : PH_OP;
      end
      PH_SKIP: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) dec_phase = PH_OP;
      end
      PH_RUN_LEN: begin
        place_run(held_nib, int'(b) + 1);
        held_nib = '0;
        dec_phase = PH_OP;
      end
      PH_RAW_HEAD: begin
        place_pixel(hi);
        skip_left = 1 + 16 * int'(held_nib) + int'(op);
        held_nib = '0;
        dec_phase = PH_RAW_PAIRS;
      end
      PH_RAW_PAIRS: begin
        place_pixel(op);
        place_pixel(hi);
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) dec_phase = PH_OP;
      end
      default: begin
        dec_phase = PH_OP;
        // full line: close first, then decode the opcode as usual
        if (op != OP_EOL && line_cnt >= cap_eff()) close_line();
        if (op == OP_EOL) begin
          close_line();
        end else if (op == OP_TEXT) begin
          held_nib = {1'b0, b[7:5]};
          dec_phase = PH_TEXT_LEN;
        end else if (op == OP_INSTR) begin
          skip_left = int'(INSTR_BYTES);
          dec_phase = PH_SKIP;
        end else if (op >= OP_RUN_LO && op <= OP_RUN_HI) begin
          place_run(hi, int'(op) - int'(RUN_OFFSET));
        end else if (op == OP_RUN_LEN) begin
          held_nib = hi;
          dec_phase = PH_RUN_LEN;
        end else if (op == OP_RAW1) begin
          place_pixel(hi);
        end else if (op == OP_RAW_PR) begin
          skip_left = int'(hi) + 1;
          dec_phase = PH_RAW_PAIRS;
        end else if (op == OP_RAW_HD) begin
          held_nib = hi;
          dec_phase = PH_RAW_HEAD;
        end
      end
    endcase
    if (beat.stream_end) begin
      if (res_n == 0 || !res_buf[res_n-1].line_end) close_line();
      dec_phase = PH_OP;
      held_nib = '0;
      skip_left = 0;
    end
    if (res_n > 0) res_buf[res_n-1].last_of_item = 1'b1;
    for (int unsigned i = 0; i < res_n; i++) decoded_q.push_back(res_buf[i]);
  endtask

  // stream driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_valid <= 1'b0;
      stream_beat  <= '0;
    end else begin
      if (stream_valid && stream_ready) decode_byte(stream_beat);
      if (!stream_valid || stream_ready) begin
        if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          stream_valid <= 1'b1;
          stream_beat  <= stream_q.pop_front();
        end else begin
          stream_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (decoded_q.size() == 0) begin
          $error("result beat with nothing expected: %p", res_beat);
          mismatch_cnt++;
        end else begin
          exp_res = decoded_q.pop_front();
          if (res_beat.pixel !== exp_res.pixel) begin
            $error("pixel: expected %0d, got %0d", exp_res.pixel, res_beat.pixel);
            mismatch_cnt++;
          end
          if (res_beat.run_count !== exp_res.run_count) begin
            $error("run_count: expected %0d, got %0d", exp_res.run_count, res_beat.run_count);
            mismatch_cnt++;
          end
          if (res_beat.overflow !== exp_res.overflow) begin
            $error("overflow: expected %0d, got %0d", exp_res.overflow, res_beat.overflow);
            mismatch_cnt++;
          end
          if (res_beat.line_end !== exp_res.line_end) begin
            $error("line_end: expected %0d, got %0d", exp_res.line_end, res_beat.line_end);
            mismatch_cnt++;
          end
          if (res_beat.line_length !== exp_res.line_length) begin
            $error("line_length: expected %0d, got %0d", exp_res.line_length,
                   res_beat.line_length);
            mismatch_cnt++;
          end
          if (res_beat.last_of_item !== exp_res.last_of_item) begin
            $error("last_of_item: expected %0d, got %0d", exp_res.last_of_item,
                   res_beat.last_of_item);
            mismatch_cnt++;
          end
        end
      end
      res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_nibble_rle_scanline_decoder: done, errors");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b, input bit e, input bit counts);
    in_t beat;
    beat.stream_byte = b;
    beat.stream_end  = e;
    stream_q.push_back(beat);
    if (counts) counted_items++;
  endtask

  function automatic bit stream_break();
    return $urandom_range(99) < end_pct;
  endfunction

  task automatic wait_idle();
    while (stream_q.size() != 0 || stream_valid || decoded_q.size() != 0) @(posedge clk_i);
  endtask

  // one well-formed record with random content, or a stray byte now and then
  task automatic gen_record(input bit heavy);
    int unsigned pick;
    int unsigned n;
    logic [3:0]  v;
    logic [3:0]  len_hi;
    logic [2:0]  text_hi;
    logic [7:0]  b;
    pick = $urandom_range(99);
    v    = 4'($urandom_range(15));
    if (heavy && pick < 70) begin
      queue_byte({v, OP_RUN_LEN}, 1'b0, 1'b1);
      queue_byte(8'($urandom_range(255, 128)), 1'b0, 1'b1);
    end else if (pick < 8) begin
      queue_byte({v, OP_EOL}, stream_break(), 1'b1);
    end else if (pick < 12) begin
      text_hi = ($urandom_range(9) == 0) ? 3'd1 : 3'd0;
      b = (text_hi != 0) ? 8'($urandom_range(255)) : 8'($urandom_range(6));
      queue_byte({text_hi, v[0], OP_TEXT}, stream_break(), 1'b1);
      queue_byte(b, stream_break(), 1'b1);
      n = 256 * int'(text_hi) + int'(b);
      for (int unsigned k = 0; k < n; k++) queue_byte(8'($urandom_range(255)), 1'b0, 1'b0);
    end else if (pick < 16) begin
      queue_byte({v, OP_INSTR}, stream_break(), 1'b1);
      for (int unsigned k = 0; k < INSTR_BYTES; k++)
        queue_byte(8'($urandom_range(255)), stream_break(), 1'b0);
    end else if (pick < 46) begin
      queue_byte({v, 4'($urandom_range(OP_RUN_HI, OP_RUN_LO))}, stream_break(), 1'b1);
    end else if (pick < 61) begin
      queue_byte({v, OP_RUN_LEN}, stream_break(), 1'b1);
      queue_byte(8'($urandom_range(255)), stream_break(), 1'b1);
    end else if (pick < 73) begin
      queue_byte({v, OP_RAW1}, stream_break(), 1'b1);
    end else if (pick < 79) begin
      queue_byte({v, OP_RAW_PR}, stream_break(), 1'b1);
      for (int unsigned k = 0; k <= v; k++)
        queue_byte(8'($urandom_range(255)), stream_break(), 1'b1);
    end else if (pick < 85) begin
      len_hi = ($urandom_range(29) == 0) ? 4'($urandom_range(15)) : 4'd0;
      b = 8'($urandom_range(255));
      queue_byte({len_hi, OP_RAW_HD}, stream_break(), 1'b1);
      queue_byte(b, stream_break(), 1'b1);
      n = 1 + 16 * int'(len_hi) + int'(b[3:0]);
      for (int unsigned k = 0; k < n; k++)
        queue_byte(8'($urandom_range(255)), stream_break(), 1'b1);
    end else if (pick < 90) begin
      case ($urandom_range(2))
        0:       queue_byte({v, OP_SPARE_A}, stream_break(), 1'b1);
        1:       queue_byte({v, OP_SPARE_B}, stream_break(), 1'b1);
        default: queue_byte({v, OP_SPARE_C}, stream_break(), 1'b1);
      endcase
    end else begin
      queue_byte(8'($urandom_range(255)), stream_break(), 1'b1);
    end
  endtask

  initial begin
    int unsigned phase_items;
    bit          heavy;
    bit          paused;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      cap_we    <= 1'b1;
      cap_wdata <= PHASE_CAP[ph];
      @(posedge clk_i);
      cap_we  <= 1'b0;
      cap_reg = PHASE_CAP[ph];

      if (ph < 3) begin
        send_idle_pct = 23;
        recv_idle_pct = 63;
      end else if (ph < 6) begin
        send_idle_pct = 63;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      heavy       = (PHASE_CAP[ph] >= 8192);
      end_pct     = heavy ? 0 : 3;
      phase_items = heavy ? 55 : 20;

      if (ph == 0) begin
        // capacity 20: short runs, fits, drops, full line, skips and stream ends
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'hF4, 1'b0, 1'b1);
        queue_byte(8'h09, 1'b0, 1'b1);
        queue_byte(8'hFA, 1'b0, 1'b1);
        queue_byte(8'hFF, 1'b0, 1'b1);
        queue_byte(8'h5A, 1'b0, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'hFB, 1'b0, 1'b1);
        queue_byte(8'h0C, 1'b0, 1'b1);
        queue_byte(8'hF0, 1'b0, 1'b1);
        queue_byte(8'h0D, 1'b0, 1'b1);
        queue_byte(8'h70, 1'b0, 1'b1);
        queue_byte(8'h21, 1'b0, 1'b1);
        queue_byte(8'h47, 1'b0, 1'b1);
        queue_byte(8'h46, 1'b0, 1'b1);
        queue_byte(8'h1B, 1'b0, 1'b1);
        queue_byte(8'h03, 1'b0, 1'b1);
        queue_byte(8'hFF, 1'b0, 1'b1);
        queue_byte(8'h01, 1'b0, 1'b1);
        queue_byte(8'h01, 1'b0, 1'b1);
        queue_byte(8'hAA, 1'b0, 1'b0);
        queue_byte(8'h01, 1'b0, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'h02, 1'b0, 1'b1);
        for (int unsigned k = 0; k < INSTR_BYTES; k++)
          queue_byte((k % 2 == 0) ? 8'h00 : 8'hFF, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b1, 1'b1);
        queue_byte(8'h03, 1'b1, 1'b1);
        queue_byte(8'h0A, 1'b0, 1'b1);
        queue_byte(8'h10, 1'b1, 1'b1);
      end

      if (ph == NUM_PHASES - 1) begin
        // realign on an opcode, then the longest text block
        queue_byte(8'h00, 1'b1, 1'b1);
        queue_byte(8'hE1, 1'b0, 1'b1);
        queue_byte(8'hFF, 1'b0, 1'b1);
        for (int unsigned k = 0; k < 2047; k++) queue_byte(8'($urandom_range(255)), 1'b0, 1'b0);
      end

      counted_items = 0;
      paused = 1'b0;
      while (counted_items < phase_items) begin
        if (ph == PRESSURE_PH && !paused && counted_items >= phase_items / 2) begin
          // hold the stream back until every outstanding result beat is out
          wait_idle();
          paused = 1'b1;
        end
        gen_record(heavy);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && decoded_q.size() == 0) begin
      $display("tb_nibble_rle_scanline_decoder: done, clean");
    end else begin
      $display("tb_nibble_rle_scanline_decoder: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
